// ----- hdl/ssmf_pkg.sv -----
// Package for the SIP stream message framer: opcodes, result kinds, literal tables.
// Depends on nothing; used by all framer modules.
package ssmf_pkg;

    localparam int unsigned LengthBitsDefault = 31;
    localparam int unsigned CountBits = 21;
    localparam logic [CountBits-1:0] CountMax = '1;
    localparam logic [CountBits-1:0] LimitReset = 21'd65536;
    localparam int unsigned NumLiterals = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [1:0] OpData    = 2'd0;
    localparam logic [1:0] OpFlush   = 2'd1;
    localparam logic [1:0] OpDiscard = 2'd2;
    localparam logic [1:0] OpIgnore  = 2'd3;

    localparam logic [1:0] KindMid   = 2'd0;
    localparam logic [1:0] KindLast  = 2'd1;
    localparam logic [1:0] KindDrop  = 2'd2;
    localparam logic [1:0] KindFlush = 2'd3;

    localparam logic [1:0] PhSeek  = 2'd0;
    localparam logic [1:0] PhDigit = 2'd1;
    localparam logic [1:0] PhRead  = 2'd2;
    localparam logic [1:0] PhDone  = 2'd3;

    localparam logic [7:0] ChCr = 8'd13;
    localparam logic [7:0] ChLf = 8'd10;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_cmd;

    function automatic logic [3:0] lit_len(input logic [1:0] idx);
        logic [3:0] r;
        begin
            r = (idx == 2'd3) ? 4'd2 : 4'd15;
            return r;
        end
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [8*15-1:0] s;
        begin
            case (idx)
                2'd0: s = "Content-Length:";
                2'd1: s = "content-length:";
                2'd2: s = "CONTENT-LENGTH:";
                default: s = {104'd0, "l:"};
            endcase
            if (idx == 2'd3) begin
                return (pos == 4'd0) ? 8'h6C : 8'h3A;
            end
            return s[8*(14 - 32'(pos)) +: 8];
        end
    endfunction

endpackage

// ----- hdl/ssmf_front.sv -----
// Front part of the framer: input handshake, opcode screening and a short command queue.
// Depends on ssmf_pkg.
module ssmf_front
    import ssmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_end,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_take
);

    t_cmd r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    // Opcode three has no effect, so it is accepted but never queued.
    assign o_stall     = (r_cnt == 2'(QueueDepth));
    assign push        = i_valid && !o_stall && (i_opcode != OpIgnore);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{opcode: i_opcode, data_byte: i_data_byte, chunk_end: i_chunk_end};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QueueDepth)) |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");

endmodule

// ----- hdl/ssmf_back.sv -----
// Back part of the framer: literal matchers, terminator search, body counter, result register.
// Depends on ssmf_pkg.
module ssmf_back
    import ssmf_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_take,
    input  logic [CountBits-1:0] i_limit,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind
);

    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    logic [1:0]             r_term, n_term;
    logic [CountBits-1:0]   r_hcnt, n_hcnt;
    logic                   r_in_body, n_in_body;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [3:0]             r_pos [NumLiterals];
    logic [3:0]             n_pos [NumLiterals];
    logic [1:0]             r_ph [NumLiterals];
    logic [1:0]             n_ph [NumLiterals];
    logic [LENGTH_BITS-1:0] r_val [NumLiterals];
    logic [LENGTH_BITS-1:0] n_val [NumLiterals];
    logic                   emit, n_ovalid;
    logic [1:0]             kind;
    logic [7:0]             ob;

    assign o_cmd_take = !o_valid || !i_stall;

    always_comb begin
        logic [7:0] b;
        logic dig;
        logic [3:0] d;
        logic [3:0] p;
        logic [LENGTH_BITS+3:0] prod;
        logic [LENGTH_BITS-1:0] len;
        logic found, done;
        logic [1:0] want;
        b = i_cmd.data_byte;
        dig = (b >= 8'h30) && (b <= 8'h39);
        d = 4'(b - 8'h30);
        n_term = r_term;
        n_hcnt = r_hcnt;
        n_in_body = r_in_body;
        n_left = r_left;
        n_pos = r_pos;
        n_ph = r_ph;
        n_val = r_val;
        emit = 1'b0;
        kind = KindMid;
        ob = b;
        len = '0;
        found = 1'b0;
        done = 1'b0;
        want = 2'd0;
        p = 4'd0;
        prod = '0;
        case (i_cmd.opcode)
            OpFlush: begin
                ob = 8'd0;
                kind = KindFlush;
                emit = (r_hcnt != '0) || r_in_body;
                n_term = '0; n_hcnt = '0; n_in_body = 1'b0; n_left = '0;
                for (int i = 0; i < NumLiterals; i++) begin
                    n_pos[i] = '0; n_ph[i] = PhSeek; n_val[i] = '0;
                end
            end
            OpDiscard: begin
                n_term = '0; n_hcnt = '0; n_in_body = 1'b0; n_left = '0;
                for (int i = 0; i < NumLiterals; i++) begin
                    n_pos[i] = '0; n_ph[i] = PhSeek; n_val[i] = '0;
                end
            end
            OpData: begin
                emit = 1'b1;
                if (r_in_body) begin
                    n_left = (r_left != '0) ? r_left - 1'b1 : r_left;
                    if (n_left == '0) begin
                        n_in_body = 1'b0;
                        kind = KindLast;
                    end
                end else begin
                    if (r_hcnt != CountMax) n_hcnt = r_hcnt + 1'b1;
                    for (int i = 0; i < NumLiterals; i++) begin
                        case (r_ph[i])
                            PhSeek: begin
                                p = (r_pos[i] >= lit_len(2'(i))) ? 4'd0 : r_pos[i];
                                if (b == lit_char(2'(i), p)) begin
                                    p = p + 4'd1;
                                    if (p >= lit_len(2'(i))) begin
                                        n_ph[i] = PhDigit;
                                        p = 4'd0;
                                    end
                                end else if (b == lit_char(2'(i), 4'd0)) begin
                                    p = 4'd1;
                                end else begin
                                    p = 4'd0;
                                end
                                n_pos[i] = p;
                            end
                            PhDigit: begin
                                if (dig) begin
                                    n_val[i] = LENGTH_BITS'(d);
                                    n_ph[i] = PhRead;
                                end
                            end
                            PhRead: begin
                                if (dig) begin
                                    prod = {r_val[i], 3'b000} + {2'b00, r_val[i], 1'b0}
                                           + (LENGTH_BITS+4)'(d);
                                    n_val[i] = (prod > (LENGTH_BITS+4)'(LenMax)) ?
                                               LenMax : prod[LENGTH_BITS-1:0];
                                end else begin
                                    n_ph[i] = PhDone;
                                end
                            end
                            default: ;
                        endcase
                    end
                    want = r_term;
                    if (b == ((want == 2'd0 || want == 2'd2) ? ChCr : ChLf)) begin
                        if (want == 2'd3) begin
                            done = 1'b1;
                            n_term = 2'd0;
                        end else begin
                            n_term = want + 2'd1;
                        end
                    end else begin
                        n_term = (b == ChCr) ? 2'd1 : 2'd0;
                    end
                    if (done) begin
                        for (int i = 0; i < NumLiterals; i++) begin
                            if (!found && n_ph[i] >= PhRead) begin
                                found = 1'b1;
                                len = n_val[i];
                            end
                        end
                        n_term = '0; n_hcnt = '0; n_left = '0;
                        for (int i = 0; i < NumLiterals; i++) begin
                            n_pos[i] = '0; n_ph[i] = PhSeek; n_val[i] = '0;
                        end
                        if (len == '0) begin
                            kind = KindLast;
                        end else begin
                            n_in_body = 1'b1;
                            n_left = len;
                        end
                    end else if (i_cmd.chunk_end && n_hcnt > i_limit) begin
                        kind = KindDrop;
                        n_term = '0; n_hcnt = '0; n_left = '0;
                        for (int i = 0; i < NumLiterals; i++) begin
                            n_pos[i] = '0; n_ph[i] = PhSeek; n_val[i] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_ovalid = o_valid;
        if (!i_stall) n_ovalid = 1'b0;
        if (i_cmd_valid && o_cmd_take && emit) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && o_cmd_take && emit) begin
            o_out_byte <= ob;
            o_kind <= kind;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_term <= '0;
            r_hcnt <= '0;
            r_in_body <= 1'b0;
            r_left <= '0;
            for (int i = 0; i < NumLiterals; i++) begin
                r_pos[i] <= '0; r_ph[i] <= PhSeek; r_val[i] <= '0;
            end
        end else begin
            o_valid <= n_ovalid;
            if (i_cmd_valid && o_cmd_take) begin
                r_term <= n_term;
                r_hcnt <= n_hcnt;
                r_in_body <= n_in_body;
                r_left <= n_left;
                r_pos <= n_pos;
                r_ph <= n_ph;
                r_val <= n_val;
            end
        end
    end

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_left != '0)) else $error("body open with zero count");
    a_body_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_hcnt == '0)) else $error("header count during body");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_out_byte)))
        else $error("result lost under stall");

endmodule

// ----- hdl/sip_stream_message_framer_core.sv -----
// Top level of the SIP stream message framer: configuration register and the two parts.
// Depends on ssmf_pkg, ssmf_front and ssmf_back.
//
// Usage: one stream byte or command enters per transaction on the input channel
// (i_valid / o_stall). Opcode 0 is a data byte, 1 flushes a pending message and
// 2 discards it. Each data byte comes back as one transaction on the output
// channel (o_valid / i_stall) with a kind: inside message, last byte of message,
// or message dropped when an open header grows past the limit at a chunk end.
// A flush of a pending message returns one marker transaction of kind 3.
// One transaction per cycle passes while the receiver does not stall; the back part
// updates all matchers, the terminator search and the body counter for each byte.
// From input acceptance to result valid, a command passes through the two-entry
// command queue and then the result register. When the receiver stalls, the result
// register holds, the queue fills, and o_stall rises once both queue entries are
// occupied. The user is to write the header limit over i_cfg_valid / o_cfg_ready
// only while idle; the block itself does not enforce this.
// Synchronous reset clears all message state and sets the limit to 65536.
module sip_stream_message_framer_core
    import ssmf_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CountBits-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_chunk_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_kind
);

    logic [CountBits-1:0] r_limit;
    logic cmd_valid, cmd_take;
    t_cmd cmd;

    // The register is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    ssmf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_data_byte(i_data_byte), .i_chunk_end(i_chunk_end),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    ssmf_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .i_limit(r_limit),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_kind(o_kind)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for sip_stream_message_framer_core: directed and random byte streams.
// Depends on ssmf_pkg and the framer RTL; it holds its own behavioral predictor of the framer.
module tb_top
    import ssmf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [30:0] LenMax = '1;
    localparam int NumMessagesShown = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
    } t_framed_byte;

    // The scoreboard mirrors the framer state. Each accepted transaction on the
    // input channel is applied to that mirror, and any byte it produces is queued
    // until the matching output transaction arrives.
    class framer_scoreboard;
        logic [20:0] header_limit;
        logic [1:0]  crlf_progress;
        logic [20:0] header_bytes;
        logic        body_open;
        logic [30:0] body_remaining;
        logic [3:0]  match_pos[NumLiterals];
        logic [1:0]  match_phase[NumLiterals];
        logic [30:0] captured_len[NumLiterals];
        t_framed_byte expected_bytes[$];
        int mismatches;

        function void clear_message();
            crlf_progress = 0;
            header_bytes = 0;
            body_open = 0;
            body_remaining = 0;
            for (int i = 0; i < NumLiterals; i++) begin
                match_pos[i] = 0;
                match_phase[i] = PhSeek;
                captured_len[i] = 0;
            end
        endfunction

        function void reset_state();
            header_limit = LimitReset;
            mismatches = 0;
            clear_message();
        endfunction

        function void set_limit(logic [20:0] value);
            header_limit = value;
        endfunction

        function logic [7:0] literal_char(int idx, int pos);
            string text;
            case (idx)
                0: text = "Content-Length:";
                1: text = "content-length:";
                2: text = "CONTENT-LENGTH:";
                default: text = "l:";
            endcase
            return text[pos];
        endfunction

        function void advance_literal(int idx, logic [7:0] b);
            int len;
            int p;
            logic is_digit;
            longint d;
            longint v;
            len = (idx == 3) ? 2 : 15;
            is_digit = (b >= "0") && (b <= "9");
            d = b - "0";
            case (match_phase[idx])
                PhSeek: begin
                    p = match_pos[idx];
                    if (p >= len) p = 0;
                    if (b == literal_char(idx, p)) begin
                        p++;
                        if (p >= len) begin
                            match_phase[idx] = PhDigit;
                            p = 0;
                        end
                    end else if (b == literal_char(idx, 0)) begin
                        p = 1;
                    end else begin
                        p = 0;
                    end
                    match_pos[idx] = 4'(p);
                end
                PhDigit: begin
                    if (is_digit) begin
                        captured_len[idx] = 31'(d);
                        match_phase[idx] = PhRead;
                    end
                end
                PhRead: begin
                    if (is_digit) begin
                        v = captured_len[idx];
                        // The captured length saturates instead of wrapping.
                        if (v > (longint'(LenMax) - d) / 10) v = LenMax;
                        else v = v * 10 + d;
                        captured_len[idx] = 31'(v);
                    end else begin
                        match_phase[idx] = PhDone;
                    end
                end
                default: ;
            endcase
        endfunction

        // Returns 1 when this byte completes CR LF CR LF.
        function logic advance_terminator(logic [7:0] b);
            logic [7:0] want;
            want = (crlf_progress == 0 || crlf_progress == 2) ? ChCr : ChLf;
            if (b == want) begin
                if (crlf_progress == 3) begin
                    crlf_progress = 0;
                    return 1;
                end
                crlf_progress++;
            end else begin
                crlf_progress = (b == ChCr) ? 2'd1 : 2'd0;
            end
            return 0;
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] b, logic chunk_end);
            t_framed_byte r;
            logic [30:0] len;
            r.out_byte = b;
            r.kind = KindMid;
            case (op)
                OpFlush: begin
                    if (header_bytes != 0 || body_open) begin
                        clear_message();
                        r.out_byte = 0;
                        r.kind = KindFlush;
                        expected_bytes.push_back(r);
                    end
                end
                OpDiscard: clear_message();
                OpData: begin
                    if (body_open) begin
                        if (body_remaining > 0) body_remaining--;
                        if (body_remaining == 0) begin
                            body_open = 0;
                            r.kind = KindLast;
                        end
                    end else begin
                        if (header_bytes != CountMax) header_bytes++;
                        for (int i = 0; i < NumLiterals; i++) advance_literal(i, b);
                        if (advance_terminator(b)) begin
                            // The first literal in priority order with digits wins.
                            len = 0;
                            for (int i = NumLiterals - 1; i >= 0; i--)
                                if (match_phase[i] >= PhRead) len = captured_len[i];
                            clear_message();
                            if (len == 0) begin
                                r.kind = KindLast;
                            end else begin
                                body_open = 1;
                                body_remaining = len;
                            end
                        end else if (chunk_end && header_bytes > header_limit) begin
                            clear_message();
                            r.kind = KindDrop;
                        end
                    end
                    expected_bytes.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void report_error(string what);
            mismatches++;
            if (mismatches <= NumMessagesShown) $display("ERROR at %0t: %s", $realtime, what);
        endfunction

        function void check_result(logic [7:0] b, logic [1:0] k);
            t_framed_byte e;
            if (expected_bytes.size() == 0) begin
                report_error($sformatf("unexpected byte %02h kind %0d", b, k));
                return;
            end
            e = expected_bytes.pop_front();
            if (b != e.out_byte)
                report_error($sformatf("out_byte expected %02h actual %02h", e.out_byte, b));
            if (k != e.kind)
                report_error($sformatf("kind expected %0d actual %0d", e.kind, k));
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [20:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_opcode = OpData;
    logic [7:0]  i_data_byte = 0;
    logic        i_chunk_end = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;

    framer_scoreboard sb = new();
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int items_sent = 0;

    sip_stream_message_framer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_data_byte(i_data_byte), .i_chunk_end(i_chunk_end),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_kind(o_kind)
    );

    always #5 i_clk = ~i_clk;

    // The receiver changes its stall only at rising edges, so the value seen at
    // the falling edge is the one that decides the next transaction.
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < receiver_idle_pct);

    always @(negedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_out_byte, o_kind);

    // Sends one input transaction, with an optional random gap in front of it.
    // Acceptance is decided from o_stall sampled at the falling edge.
    task automatic send_item(logic [1:0] op, logic [7:0] b, logic chunk_end);
        logic stalled;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_data_byte <= b;
        i_chunk_end <= chunk_end;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            if (!stalled) sb.note_input(op, b, chunk_end);
            @(posedge i_clk);
        end while (stalled);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OpData, s[i], $urandom_range(5) == 0);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        // A flush or discard may still sit in the pipe without a result.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [20:0] value);
        logic ready;
        wait_drained();
        i_cfg_valid <= 1;
        i_cfg_data <= value;
        do begin
            @(negedge i_clk);
            ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready);
        i_cfg_valid <= 0;
        sb.set_limit(value);
    endtask

    // A random message: start line, optional length headers, CR LF CR LF, body.
    // Some messages are cut short by a flush or discard, some are plain noise.
    task automatic random_message();
        string hdr;
        string names[5];
        int body_len;
        int pick;
        names = '{"Content-Length:", "content-length:", "CONTENT-LENGTH:", "l:", "Content-Lx:"};
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 12))
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            return;
        end
        hdr = "INVITE sip:a SIP/2.0\r\n";
        if ($urandom_range(3) == 0) hdr = "ll:Co";
        repeat ($urandom_range(0, 2)) begin
            body_len = $urandom_range(12);
            hdr = {hdr, names[$urandom_range(4)],
                   ($urandom_range(1) ? " " : ""), $sformatf("%0d", body_len), "\r\n"};
        end
        if ($urandom_range(3) == 0) hdr = {hdr, "\r\r\n\n"};
        hdr = {hdr, "\r\n"};
        send_text(hdr);
        repeat ($urandom_range(0, 12))
            send_item(OpData, 8'($urandom_range(255)), 1'($urandom_range(1)));
        if (pick < 20)
            send_item(pick < 15 ? OpFlush : OpDiscard, 8'($urandom_range(255)), 1'b0);
    endtask

    task automatic random_phase(int snd, int rcv, int count);
        int target;
        sender_idle_pct = snd;
        receiver_idle_pct = rcv;
        target = items_sent + count;
        while (items_sent < target) begin
            random_message();
            if ($urandom_range(30) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: each literal, the short form, saturation, every opcode.
        send_text("Content-Length: 2\r\n\r\nab");
        send_text("l:0\r\n\r\n");
        send_text("CONTENT-LENGTH:99999999999\r\n\r\nxy");
        send_item(OpFlush, 8'hFF, 1);
        send_item(OpFlush, 8'h00, 0);
        send_item(OpIgnore, 8'hA5, 1);
        send_text("content-length:1\r\n");
        send_item(OpDiscard, 8'h5A, 0);
        send_item(OpData, 8'hFF, 1);
        send_item(OpFlush, 8'h00, 0);
        write_limit(21'd4);
        send_text("abcde");
        send_item(OpData, 8'h00, 1);

        random_phase(19, 77, 370);
        write_limit(21'd40);
        random_phase(77, 19, 370);
        write_limit(21'd1048576);
        random_phase(0, 0, 370);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.outstanding() != 0) sb.report_error("results still expected at the end");
        if (sb.mismatches == 0) begin
            $display("sip_stream_message_framer_core verification clean");
        end else begin
            $display("sip_stream_message_framer_core verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("sip_stream_message_framer_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ssmf_pkg.sv
hdl/ssmf_front.sv
hdl/ssmf_back.sv
hdl/sip_stream_message_framer_core.sv
tb/tb_top.sv
